/* hdl/ccpm_pkg.sv */
// Shared types, command codes and helpers for the CCP master read sequencer.
package ccpm_pkg;

  // Frame and field widths
  localparam int FRAME_W = 64;
  localparam int ADDR_W  = 32;
  localparam int VALUE_W = 32;
  localparam int TICK_W  = 16;

  // Stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int S_TDATA_W = 112;
  localparam int M_TDATA_W = 120;

  // Configuration port
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_ENDIAN  = 1'b1;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd2;

  // Request kinds carried in tuser
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_FRAME   = 2'd1;
  localparam logic [1:0] REQ_CONNECT = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  // Variable kinds
  localparam logic [2:0] KIND_U8  = 3'd0;
  localparam logic [2:0] KIND_S8  = 3'd1;
  localparam logic [2:0] KIND_U16 = 3'd2;
  localparam logic [2:0] KIND_S16 = 3'd3;
  localparam logic [2:0] KIND_U32 = 3'd4;
  localparam logic [2:0] KIND_S32 = 3'd5;

  // Command codes and reply markers
  localparam logic [7:0] CMD_CONNECT     = 8'h01;
  localparam logic [7:0] CMD_SET_MTA     = 8'h02;
  localparam logic [7:0] CMD_UPLOAD      = 8'h04;
  localparam logic [7:0] CMD_GET_VERSION = 8'h1B;
  localparam logic [7:0] CRM_MARK        = 8'hFF;
  localparam logic [7:0] RC_ACK          = 8'h00;

  // Requested protocol version 2.1
  localparam logic [7:0] VER_REQ_MAJOR = 8'd2;
  localparam logic [7:0] VER_REQ_MINOR = 8'd1;

  // Upload sizes
  localparam logic [7:0] UPLOAD_SIZE_1 = 8'd1;
  localparam logic [7:0] UPLOAD_SIZE_2 = 8'd2;
  localparam logic [7:0] UPLOAD_SIZE_4 = 8'd4;

  // Sequencer phase codes as seen on the result word
  localparam logic [2:0] CODE_INIT    = 3'd0;
  localparam logic [2:0] CODE_CONNECT = 3'd1;
  localparam logic [2:0] CODE_VERSION = 3'd2;
  localparam logic [2:0] CODE_WAIT    = 3'd3;
  localparam logic [2:0] CODE_SETMTA  = 3'd4;
  localparam logic [2:0] CODE_UPLOAD  = 3'd5;

  typedef enum logic [5:0] {
    PH_INIT    = 6'b000001,
    PH_CONNECT = 6'b000010,
    PH_VERSION = 6'b000100,
    PH_WAIT    = 6'b001000,
    PH_SETMTA  = 6'b010000,
    PH_UPLOAD  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] timeout_limit;
    logic              ecu_big_endian;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FRAME_W-1:0] rx_frame;
    logic [ADDR_W-1:0]  read_address;
    logic [7:0]         read_extension;
    logic [2:0]         read_kind;
  } item_t;

  typedef struct packed {
    logic               tx_valid;
    logic [FRAME_W-1:0] tx_frame;
    logic [2:0]         seq_state;
    logic               link_up;
    logic [7:0]         version_major;
    logic [7:0]         version_minor;
    logic               awaiting_reply;
    logic               counter_mismatch;
    logic               read_done;
    logic               read_ok;
    logic [VALUE_W-1:0] read_value;
  } result_t;

  // Byte k of a frame, byte1 in the top bits
  function automatic logic [7:0] frame_byte(input logic [FRAME_W-1:0] f, input int k);
    frame_byte = f[(8-k)*8 +: 8];
  endfunction

  function automatic logic [2:0] phase_code(input phase_t ph);
    case (ph)
      PH_INIT:    phase_code = CODE_INIT;
      PH_CONNECT: phase_code = CODE_CONNECT;
      PH_VERSION: phase_code = CODE_VERSION;
      PH_WAIT:    phase_code = CODE_WAIT;
      PH_SETMTA:  phase_code = CODE_SETMTA;
      PH_UPLOAD:  phase_code = CODE_UPLOAD;
      default:    phase_code = CODE_INIT;
    endcase
  endfunction

endpackage

/* hdl/ccpm_apb.sv */
// Configuration registers behind the APB-style port.
module ccpm_apb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ccpm_pkg::PADDR_W-1:0]  paddr,
  input  logic [ccpm_pkg::PDATA_W-1:0]  pwdata,
  output logic [ccpm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output ccpm_pkg::cfg_t                cfg
);
  import ccpm_pkg::*;

  logic               wr_en;
  logic               reg_sel;
  logic [TICK_W-1:0]  timeout_limit;
  logic               ecu_big_endian;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit  <= TIMEOUT_RESET;
      ecu_big_endian <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TIMEOUT: timeout_limit  <= pwdata[TICK_W-1:0];
        REG_ENDIAN:  ecu_big_endian <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_TIMEOUT: prdata = {{(PDATA_W-TICK_W){1'b0}}, timeout_limit};
      REG_ENDIAN:  prdata = {{(PDATA_W-1){1'b0}}, ecu_big_endian};
      default:     prdata = '0;
    endcase
  end

  assign cfg.timeout_limit  = timeout_limit;
  assign cfg.ecu_big_endian = ecu_big_endian;

endmodule

/* hdl/ccpm_core.sv */
// Protocol state and one-step update: item handling, then one sequencer run.
module ccpm_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  ccpm_pkg::item_t    item,
  input  ccpm_pkg::cfg_t     cfg,
  output ccpm_pkg::result_t  result
);
  import ccpm_pkg::*;

  phase_t              phase, phase_next;
  logic                entering, entering_next;
  logic                pending, pending_next;
  logic [7:0]          cmd_counter, cmd_counter_next;
  logic [7:0]          sent_counter, sent_counter_next;
  logic [7:0]          sent_command, sent_command_next;
  logic [TICK_W-1:0]   ticks_waited, ticks_waited_next;
  logic                connected_flag, connected_flag_next;
  logic [7:0]          ver_main, ver_main_next;
  logic [7:0]          ver_release, ver_release_next;
  logic [7:0]          last_error, last_error_next;
  logic                connect_pending, connect_pending_next;
  logic                read_pending, read_pending_next;
  logic [ADDR_W-1:0]   target_address, target_address_next;
  logic [7:0]          target_extension, target_extension_next;
  logic [2:0]          target_kind, target_kind_next;
  logic [VALUE_W-1:0]  value_reg, value_reg_next;
  logic                read_ok, read_ok_next;

  logic                mismatch;
  logic                done;
  logic                send;
  logic [7:0]          send_cmd;
  logic [7:0]          send_b3;
  logic [7:0]          send_b4;
  logic [ADDR_W-1:0]   send_tail;

  logic [7:0]          rx_b1, rx_b2, rx_b3, rx_b4, rx_b5, rx_b6, rx_b7;
  logic [15:0]         half;
  logic [VALUE_W-1:0]  upload_value;

  assign rx_b1 = frame_byte(item.rx_frame, 1);
  assign rx_b2 = frame_byte(item.rx_frame, 2);
  assign rx_b3 = frame_byte(item.rx_frame, 3);
  assign rx_b4 = frame_byte(item.rx_frame, 4);
  assign rx_b5 = frame_byte(item.rx_frame, 5);
  assign rx_b6 = frame_byte(item.rx_frame, 6);
  assign rx_b7 = frame_byte(item.rx_frame, 7);

  // Assemble upload data by width and ECU byte order
  assign half = cfg.ecu_big_endian ? {rx_b4, rx_b5} : {rx_b5, rx_b4};
  always_comb begin
    case (target_kind)
      KIND_U8:  upload_value = {24'd0, rx_b4};
      KIND_S8:  upload_value = {{24{rx_b4[7]}}, rx_b4};
      KIND_U16: upload_value = {16'd0, half};
      KIND_S16: upload_value = {{16{half[15]}}, half};
      KIND_U32, KIND_S32:
        upload_value = cfg.ecu_big_endian ? {rx_b4, rx_b5, rx_b6, rx_b7}
                                          : {rx_b7, rx_b6, rx_b5, rx_b4};
      default:  upload_value = value_reg;
    endcase
  end

  always_comb begin
    phase_next            = phase;
    entering_next         = entering;
    pending_next          = pending;
    cmd_counter_next      = cmd_counter;
    sent_counter_next     = sent_counter;
    sent_command_next     = sent_command;
    ticks_waited_next     = ticks_waited;
    connected_flag_next   = connected_flag;
    ver_main_next         = ver_main;
    ver_release_next      = ver_release;
    last_error_next       = last_error;
    connect_pending_next  = connect_pending;
    read_pending_next     = read_pending;
    target_address_next   = target_address;
    target_extension_next = target_extension;
    target_kind_next      = target_kind;
    value_reg_next        = value_reg;
    read_ok_next          = read_ok;
    mismatch              = 1'b0;
    done                  = 1'b0;
    send                  = 1'b0;
    send_cmd              = CMD_CONNECT;
    send_b3               = 8'd0;
    send_b4               = 8'd0;
    send_tail             = '0;

    // Handle the incoming word
    case (item.req_type)
      REQ_TICK: begin
        if (pending) begin
          if (ticks_waited >= cfg.timeout_limit) pending_next = 1'b0;
          else ticks_waited_next = ticks_waited + 16'd1;
        end
      end
      REQ_FRAME: begin
        if (rx_b1 == CRM_MARK) begin
          if (rx_b3 != sent_counter) begin
            mismatch = 1'b1;
          end else begin
            last_error_next = rx_b2;
            pending_next    = 1'b0;
            case (sent_command)
              CMD_CONNECT: connected_flag_next = (rx_b2 == RC_ACK);
              CMD_GET_VERSION: begin
                if (rx_b2 == RC_ACK) begin
                  ver_main_next    = rx_b4;
                  ver_release_next = rx_b5;
                end
              end
              CMD_UPLOAD: if (rx_b2 == RC_ACK) value_reg_next = upload_value;
              default: ;
            endcase
          end
        end
      end
      REQ_CONNECT: connect_pending_next = 1'b1;
      REQ_READ: begin
        read_pending_next     = 1'b1;
        target_address_next   = item.read_address;
        target_extension_next = item.read_extension;
        target_kind_next      = item.read_kind;
      end
      default: ;
    endcase

    // Run the sequencer once
    case (phase)
      PH_INIT: begin
        connected_flag_next = 1'b0;
        ver_main_next       = 8'd0;
        ver_release_next    = 8'd0;
        if (connect_pending_next) begin
          connect_pending_next = 1'b0;
          phase_next           = PH_CONNECT;
          entering_next        = 1'b1;
        end
      end
      PH_CONNECT: begin
        if (entering) begin
          send          = 1'b1;
          send_cmd      = CMD_CONNECT;
          entering_next = 1'b0;
        end else if (!pending_next) begin
          phase_next    = connected_flag_next ? PH_VERSION : PH_INIT;
          entering_next = 1'b1;
        end
      end
      PH_VERSION: begin
        if (entering) begin
          send          = 1'b1;
          send_cmd      = CMD_GET_VERSION;
          send_b3       = VER_REQ_MAJOR;
          send_b4       = VER_REQ_MINOR;
          entering_next = 1'b0;
        end else if (!pending_next && ver_main_next != 8'd0) begin
          phase_next    = PH_WAIT;
          entering_next = 1'b1;
        end else if (!pending_next && ver_release_next == 8'd0) begin
          phase_next    = PH_INIT;
          entering_next = 1'b1;
        end
      end
      PH_WAIT: begin
        if (entering) begin
          entering_next = 1'b0;
        end else if (read_pending_next) begin
          read_pending_next = 1'b0;
          phase_next        = PH_SETMTA;
          entering_next     = 1'b1;
        end
      end
      PH_SETMTA: begin
        if (entering) begin
          send          = 1'b1;
          send_cmd      = CMD_SET_MTA;
          send_b4       = target_extension_next;
          send_tail     = target_address_next;
          entering_next = 1'b0;
        end else if (!pending_next) begin
          phase_next    = (last_error_next == RC_ACK) ? PH_UPLOAD : PH_WAIT;
          entering_next = 1'b1;
        end
      end
      PH_UPLOAD: begin
        if (entering) begin
          send_cmd = CMD_UPLOAD;
          case (target_kind_next)
            KIND_U8, KIND_S8:   begin send = 1'b1; send_b3 = UPLOAD_SIZE_1; end
            KIND_U16, KIND_S16: begin send = 1'b1; send_b3 = UPLOAD_SIZE_2; end
            KIND_U32, KIND_S32: begin send = 1'b1; send_b3 = UPLOAD_SIZE_4; end
            default: ;
          endcase
          entering_next = 1'b0;
        end else if (!pending_next) begin
          read_ok_next  = (last_error_next == RC_ACK);
          done          = 1'b1;
          phase_next    = PH_WAIT;
          entering_next = 1'b1;
        end
      end
      default: ;
    endcase

    // Issue a command: bump the counter and arm the reply wait
    if (send) begin
      cmd_counter_next  = cmd_counter + 8'd1;
      sent_counter_next = cmd_counter + 8'd1;
      sent_command_next = send_cmd;
      pending_next      = 1'b1;
      ticks_waited_next = '0;
    end
  end

  // Result word for this step
  always_comb begin
    result.tx_valid         = send;
    result.tx_frame         = send ? {send_cmd, cmd_counter_next, send_b3, send_b4, send_tail}
                                   : '0;
    result.seq_state        = phase_code(phase_next);
    result.link_up          = connected_flag_next;
    result.version_major    = ver_main_next;
    result.version_minor    = ver_release_next;
    result.awaiting_reply   = pending_next;
    result.counter_mismatch = mismatch;
    result.read_done        = done;
    result.read_ok          = read_ok_next;
    result.read_value       = value_reg_next;
  end

  // Advance state on each word taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_INIT;
      entering         <= 1'b0;
      pending          <= 1'b0;
      cmd_counter      <= 8'd0;
      sent_counter     <= 8'd0;
      sent_command     <= 8'd0;
      ticks_waited     <= '0;
      connected_flag   <= 1'b0;
      ver_main         <= 8'd0;
      ver_release      <= 8'd0;
      last_error       <= 8'd0;
      connect_pending  <= 1'b0;
      read_pending     <= 1'b0;
      target_address   <= '0;
      target_extension <= 8'd0;
      target_kind      <= 3'd0;
      value_reg        <= '0;
      read_ok          <= 1'b0;
    end else if (fire) begin
      phase            <= phase_next;
      entering         <= entering_next;
      pending          <= pending_next;
      cmd_counter      <= cmd_counter_next;
      sent_counter     <= sent_counter_next;
      sent_command     <= sent_command_next;
      ticks_waited     <= ticks_waited_next;
      connected_flag   <= connected_flag_next;
      ver_main         <= ver_main_next;
      ver_release      <= ver_release_next;
      last_error       <= last_error_next;
      connect_pending  <= connect_pending_next;
      read_pending     <= read_pending_next;
      target_address   <= target_address_next;
      target_extension <= target_extension_next;
      target_kind      <= target_kind_next;
      value_reg        <= value_reg_next;
      read_ok          <= read_ok_next;
    end
  end

  // The expected reply counter always tracks the last counter sent
  a_counter_track: assert property (@(posedge clk) disable iff (rst)
    sent_counter == cmd_counter)
    else $error("sent counter diverged from command counter");

  // A sent command arms the reply wait
  a_send_arms: assert property (@(posedge clk) disable iff (rst)
    fire && send |=> pending)
    else $error("command sent without pending reply");

  // Each command advances the counter by one
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    fire && send |=> cmd_counter == $past(cmd_counter) + 8'd1)
    else $error("command counter did not advance by one");

  // State holds while no word is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(cmd_counter) && $stable(phase) && $stable(pending))
    else $error("state changed without a word");

  // A finished read returns the sequencer to wait
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    fire && done |=> phase == PH_WAIT)
    else $error("read finished outside wait");

endmodule

/* hdl/ccp_master_read_sequencer_unit.sv */
// Top level of the CCP master read sequencer: input register, step core, result register.
//
//   channel   | direction | payload
//   ----------+-----------+-----------------------------------------------------
//   s_*       | in        | tuser: req_type; tdata: rx_frame, read_address,
//             |           |   read_extension, read_kind
//   m_*       | out       | tuser: tx_valid; tdata: tx_frame .. read_value
//   APB       | in        | timeout_limit at 0x0, ecu_big_endian at 0x4
//
// One word per cycle sustained while m_tready keeps the result register draining; a word
// is held in the input register and its result is then shown from the result register.
// The step core (item handling plus one sequencer run) sits between the two
// registers and updates the protocol state as it loads the result register.
// rst clears all protocol state and both valid flags; configuration resets to
// timeout 2 and little-endian ECU order.
// A stalled result register holds its word; the input register still takes a
// new word in the same cycle that the result is drained.
module ccp_master_read_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst,
  // Input words
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ccpm_pkg::S_TDATA_W-1:0] s_tdata,  // rx_frame, read_address, read_extension,
                                                   // read_kind, zero pad
  input  logic [1:0]                     s_tuser,  // req_type
  // Result words
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ccpm_pkg::M_TDATA_W-1:0] m_tdata,  // tx_frame, seq_state, link_up,
                                                   // version_major, version_minor,
                                                   // awaiting_reply, counter_mismatch,
                                                   // read_done, read_ok, read_value
  output logic                           m_tuser,  // tx_valid
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ccpm_pkg::PADDR_W-1:0]   paddr,
  input  logic [ccpm_pkg::PDATA_W-1:0]   pwdata,
  output logic [ccpm_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import ccpm_pkg::*;

  cfg_t     cfg;
  item_t    in_item;
  logic     in_valid;
  logic     fire;
  result_t  step_result;
  result_t  out_word;
  logic     out_valid;

  ccpm_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Step a word when the result register is free or draining
  assign fire     = in_valid & (~out_valid | m_tready);
  assign s_tready = ~in_valid | fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type       <= s_tuser;
      in_item.rx_frame       <= s_tdata[63:0];
      in_item.read_address   <= s_tdata[95:64];
      in_item.read_extension <= s_tdata[103:96];
      in_item.read_kind      <= s_tdata[106:104];
    end
  end

  ccpm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_word.tx_valid;
  assign m_tdata  = {out_word.read_value, out_word.read_ok, out_word.read_done,
                     out_word.counter_mismatch, out_word.awaiting_reply,
                     out_word.version_minor, out_word.version_major,
                     out_word.link_up, out_word.seq_state, out_word.tx_frame};

  // A waiting input word is never dropped
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid)
    else $error("input word lost");

  // A stepped word always lands in the result register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("result not registered");

  // No step while a stalled result is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |-> !fire)
    else $error("result overwritten while stalled");

endmodule
